FILE: hdl/ssqt_pkg.sv
package ssqt_pkg;

   // waiting line geometry
   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0] LAST_PLACE = PTR_W'(QUEUE_DEPTH - 1);

   // field widths
   localparam int TIME_W = 16;
   localparam int ID_W = 16;
   localparam int SVC_W = 8;
   localparam int WAIT_W = 8;
   localparam int SUM_W = 32;
   localparam int ENTRY_W = ID_W + TIME_W + SVC_W;

   localparam logic [TIME_W-1:0] SIM_LENGTH_RESET = 16'd10;

   // commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic eval;
      logic check;
      logic deq;
      logic publish;
   } ssqt_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic run_tick;
      logic need_deq;
   } ssqt_stat_type;

endpackage

FILE: hdl/ssqt_ram.sv
module ssqt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ssqt_ctrl.sv
module ssqt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  ssqt_pkg::ssqt_stat_type stat,
   output ssqt_pkg::ssqt_cmd_type  cmd
);

   import ssqt_pkg::*;

   typedef enum logic [2:0] {
      IDLE,
      EVAL,
      CHECK,
      DEQ,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;
   logic      publish;

   assign req_stall = reset | (state_ff != IDLE);
   assign take = (state_ff == IDLE) & req_valid & ~req_stall;
   assign publish = (state_ff == DONE) & (~rsp_valid_ff | ~rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (take) state_in = EVAL;
         end
         EVAL: begin
            state_in = stat.run_tick ? CHECK : DONE;
         end
         CHECK: begin
            state_in = stat.need_deq ? DEQ : DONE;
         end
         DEQ: begin
            state_in = DONE;
         end
         DONE: begin
            if (publish) state_in = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // output register valid: set on publish, cleared when taken
   assign rsp_valid_in = publish | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // command decode
   always_comb begin
      cmd.capture = take;
      cmd.eval = (state_ff == EVAL);
      cmd.check = (state_ff == CHECK);
      cmd.deq = (state_ff == DEQ);
      cmd.publish = publish;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/ssqt_dpath.sv
module ssqt_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ssqt_pkg::ssqt_cmd_type               cmd,
   output ssqt_pkg::ssqt_stat_type              stat,
   input  logic                                 csr_write_enable,
   input  logic [ssqt_pkg::TIME_W-1:0]          csr_write_data,
   input  logic                                 req_mode,
   input  logic                                 req_arrive,
   input  logic [ssqt_pkg::SVC_W-1:0]           req_service_time,
   output logic [ssqt_pkg::TIME_W-1:0]          rsp_tick_time,
   output logic                                 rsp_accepted,
   output logic                                 rsp_arrival_dropped,
   output logic                                 rsp_started,
   output logic [ssqt_pkg::ID_W-1:0]            rsp_started_id,
   output logic [ssqt_pkg::TIME_W-1:0]          rsp_started_wait,
   output logic [ssqt_pkg::WAIT_W-1:0]          rsp_waiting_count,
   output logic [ssqt_pkg::ID_W-1:0]            rsp_served_total,
   output logic [ssqt_pkg::SUM_W-1:0]           rsp_wait_total,
   output logic [ssqt_pkg::ID_W-1:0]            rsp_arrived_total,
   output logic                                 rsp_run_done
);

   import ssqt_pkg::*;

   // captured item
   logic              mode_ff, mode_in;
   logic              arrive_ff, arrive_in;
   logic [SVC_W-1:0]  svc_ff, svc_in;

   // run state
   logic [TIME_W-1:0] sim_length_ff, sim_length_in;
   logic [TIME_W-1:0] sim_time_ff, sim_time_in;
   logic [SVC_W-1:0]  busy_ff, busy_in;
   logic [ID_W-1:0]   arrivals_ff, arrivals_in;
   logic [ID_W-1:0]   served_ff, served_in;
   logic [SUM_W-1:0]  wait_sum_ff, wait_sum_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  occ_ff, occ_in;

   // per-item flags
   logic              accepted_ff, accepted_in;
   logic              dropped_ff, dropped_in;
   logic              started_ff, started_in;
   logic [ID_W-1:0]   sid_ff, sid_in;
   logic [TIME_W-1:0] swait_ff, swait_in;

   // output register
   logic [TIME_W-1:0] o_time_ff;
   logic              o_accepted_ff;
   logic              o_dropped_ff;
   logic              o_started_ff;
   logic [ID_W-1:0]   o_sid_ff;
   logic [TIME_W-1:0] o_swait_ff;
   logic [WAIT_W-1:0] o_count_ff;
   logic [ID_W-1:0]   o_served_ff;
   logic [SUM_W-1:0]  o_wait_sum_ff;
   logic [ID_W-1:0]   o_arrived_ff;
   logic              o_done_ff;

   // line store
   logic               wr_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic [ID_W-1:0]    rd_id;
   logic [TIME_W-1:0]  rd_arr;
   logic [SVC_W-1:0]   rd_svc;

   logic               run_tick;
   logic               full;
   logic [TIME_W-1:0]  time_next;
   logic [ID_W-1:0]    arrivals_next;
   logic [TIME_W-1:0]  wait_now;
   logic [SUM_W:0]     sum_wide;

   assign run_tick = ~mode_ff & (sim_time_ff < sim_length_ff);
   assign full = (occ_ff >= DEPTH_CNT);
   assign time_next = sim_time_ff + TIME_W'(1);
   assign arrivals_next = arrivals_ff + ID_W'(1);

   assign stat.run_tick = run_tick;
   assign stat.need_deq = (busy_ff == '0) & (occ_ff != '0);

   // enqueue write during evaluation, head read during check
   assign wr_en = cmd.eval & run_tick & arrive_ff & ~full;
   assign wr_data = {arrivals_next, time_next, svc_ff};
   assign {rd_id, rd_arr, rd_svc} = rd_data;

   ssqt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(wr_data),
      .rd_addr(head_ff),
      .rd_data(rd_data)
   );

   // wait of the head customer and saturating total
   assign wait_now = sim_time_ff - rd_arr;
   assign sum_wide = {1'b0, wait_sum_ff} + (SUM_W + 1)'(wait_now);

   // item capture and configuration
   always_comb begin
      mode_in = mode_ff;
      arrive_in = arrive_ff;
      svc_in = svc_ff;
      if (cmd.capture) begin
         mode_in = req_mode;
         arrive_in = req_arrive;
         svc_in = req_service_time;
      end
      sim_length_in = csr_write_enable ? csr_write_data : sim_length_ff;
   end

   // run state updates
   always_comb begin
      sim_time_in = sim_time_ff;
      busy_in = busy_ff;
      arrivals_in = arrivals_ff;
      served_in = served_ff;
      wait_sum_in = wait_sum_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in = occ_ff;
      accepted_in = accepted_ff;
      dropped_in = dropped_ff;
      started_in = started_ff;
      sid_in = sid_ff;
      swait_in = swait_ff;

      if (cmd.eval) begin
         accepted_in = run_tick;
         dropped_in = run_tick & arrive_ff & full;
         started_in = 1'b0;
         sid_in = '0;
         swait_in = '0;
         if (mode_ff) begin
            sim_time_in = '0;
            busy_in = '0;
            arrivals_in = '0;
            served_in = '0;
            wait_sum_in = '0;
            head_in = '0;
            tail_in = '0;
            occ_in = '0;
         end else if (run_tick) begin
            sim_time_in = time_next;
            if (arrive_ff) begin
               arrivals_in = arrivals_next;
            end
            if (wr_en) begin
               tail_in = (tail_ff == LAST_PLACE) ? '0 : tail_ff + PTR_W'(1);
               occ_in = occ_ff + CNT_W'(1);
            end
         end
      end

      // server busy: count down
      if (cmd.check && (busy_ff != '0)) begin
         busy_in = busy_ff - SVC_W'(1);
      end

      // head customer begins service
      if (cmd.deq) begin
         started_in = 1'b1;
         sid_in = rd_id;
         swait_in = wait_now;
         head_in = (head_ff == LAST_PLACE) ? '0 : head_ff + PTR_W'(1);
         occ_in = occ_ff - CNT_W'(1);
         served_in = served_ff + ID_W'(1);
         wait_sum_in = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
         busy_in = (rd_svc == '0) ? '0 : rd_svc - SVC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sim_length_ff <= SIM_LENGTH_RESET;
         sim_time_ff <= '0;
         busy_ff <= '0;
         arrivals_ff <= '0;
         served_ff <= '0;
         wait_sum_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff <= '0;
      end else begin
         sim_length_ff <= sim_length_in;
         sim_time_ff <= sim_time_in;
         busy_ff <= busy_in;
         arrivals_ff <= arrivals_in;
         served_ff <= served_in;
         wait_sum_ff <= wait_sum_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff <= occ_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      arrive_ff <= arrive_in;
      svc_ff <= svc_in;
      accepted_ff <= accepted_in;
      dropped_ff <= dropped_in;
      started_ff <= started_in;
      sid_ff <= sid_in;
      swait_ff <= swait_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         o_time_ff <= sim_time_ff;
         o_accepted_ff <= accepted_ff;
         o_dropped_ff <= dropped_ff;
         o_started_ff <= started_ff;
         o_sid_ff <= sid_ff;
         o_swait_ff <= swait_ff;
         o_count_ff <= WAIT_W'(occ_ff);
         o_served_ff <= served_ff;
         o_wait_sum_ff <= wait_sum_ff;
         o_arrived_ff <= arrivals_ff;
         o_done_ff <= (sim_time_ff >= sim_length_ff);
      end
   end

   assign rsp_tick_time = o_time_ff;
   assign rsp_accepted = o_accepted_ff;
   assign rsp_arrival_dropped = o_dropped_ff;
   assign rsp_started = o_started_ff;
   assign rsp_started_id = o_sid_ff;
   assign rsp_started_wait = o_swait_ff;
   assign rsp_waiting_count = o_count_ff;
   assign rsp_served_total = o_served_ff;
   assign rsp_wait_total = o_wait_sum_ff;
   assign rsp_arrived_total = o_arrived_ff;
   assign rsp_run_done = o_done_ff;

endmodule

FILE: hdl/single_server_queue_sim_tick_top.sv
// Tick-driven single-server queue with a 128-place first-in first-out waiting line.
// Input channel (req_): one item per tick, or a start item (req_mode high) that
// clears the line, the time, the countdown and all totals.
// Result channel (rsp_): exactly one item per input item, in order, carrying
// the time, per-tick flags, the customer that began service and the totals.
// Configuration (csr_): csr_write_enable with csr_write_data sets the run
// length in ticks; write only while the block is idle.
// Steps: after acceptance, a start or an ignored tick goes through evaluation
// to the result; a tick without a dequeue adds a check, and a tick that starts
// a customer adds a check and a dequeue. The next item is taken the cycle after
// its result is loaded; the step order comes from the line store's
// write-then-read order with a registered read port.
// Reset: synchronous, active high; clears the run state and sets the run
// length to 10; req_stall is high during reset. Line store contents are not
// cleared, since only places written in the current run are read.
// When rsp_stall holds a result, the next item is still accepted and worked
// on, and waits in its final state until the output register is taken.
module single_server_queue_sim_tick_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [ssqt_pkg::TIME_W-1:0]          csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_mode,
   input  logic                                 req_arrive,
   input  logic [ssqt_pkg::SVC_W-1:0]           req_service_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [ssqt_pkg::TIME_W-1:0]          rsp_tick_time,
   output logic                                 rsp_accepted,
   output logic                                 rsp_arrival_dropped,
   output logic                                 rsp_started,
   output logic [ssqt_pkg::ID_W-1:0]            rsp_started_id,
   output logic [ssqt_pkg::TIME_W-1:0]          rsp_started_wait,
   output logic [ssqt_pkg::WAIT_W-1:0]          rsp_waiting_count,
   output logic [ssqt_pkg::ID_W-1:0]            rsp_served_total,
   output logic [ssqt_pkg::SUM_W-1:0]           rsp_wait_total,
   output logic [ssqt_pkg::ID_W-1:0]            rsp_arrived_total,
   output logic                                 rsp_run_done
);

   import ssqt_pkg::*;

   ssqt_cmd_type  cmd;
   ssqt_stat_type stat;

   // sequencer
   ssqt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .stat     (stat),
      .cmd      (cmd)
   );

   // queue state, line store and result register
   ssqt_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_mode           (req_mode),
      .req_arrive         (req_arrive),
      .req_service_time   (req_service_time),
      .rsp_tick_time      (rsp_tick_time),
      .rsp_accepted       (rsp_accepted),
      .rsp_arrival_dropped(rsp_arrival_dropped),
      .rsp_started        (rsp_started),
      .rsp_started_id     (rsp_started_id),
      .rsp_started_wait   (rsp_started_wait),
      .rsp_waiting_count  (rsp_waiting_count),
      .rsp_served_total   (rsp_served_total),
      .rsp_wait_total     (rsp_wait_total),
      .rsp_arrived_total  (rsp_arrived_total),
      .rsp_run_done       (rsp_run_done)
   );

endmodule

FILE: hdl/ssqt_checker.sv
module ssqt_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_accepted,
   input logic                                 rsp_arrival_dropped,
   input logic                                 rsp_started,
   input logic [ssqt_pkg::ID_W-1:0]            rsp_started_id,
   input logic [ssqt_pkg::TIME_W-1:0]          rsp_started_wait
);

   // a held result stays valid
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // one item in flight: input is stalled right after an item is taken
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // a customer start or a dropped arrival only happens on a processed tick
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_started || rsp_arrival_dropped) |-> rsp_accepted)
      else $error("tick flags set on an unprocessed item");

   // no customer started means zero id and wait
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_started |-> rsp_started_id == '0 && rsp_started_wait == '0)
      else $error("customer fields set without a start");

endmodule

bind single_server_queue_sim_tick_top ssqt_checker u_ssqt_checker (.*);
